[sv/on_demand_route_table_macros.svh]
// Assertion macros used by the route table controller.
`ifndef ON_DEMAND_ROUTE_TABLE_MACROS_SVH
`define ON_DEMAND_ROUTE_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ODRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ODRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/odrt_pkg.sv]
// Shared types, constants and codes of the route table engine.
package odrt_pkg;

    localparam int NODE_COUNT_DEF = 16;
    localparam int MAC_W          = 48;
    localparam int RT_WORD_W      = 32 + 8 + 4 + MAC_W;

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    // Item kinds
    localparam logic [1:0] KIND_RREQ  = 2'd0;
    localparam logic [1:0] KIND_RREP  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_LOCAL = 2'd3;

    // Result actions
    localparam logic [2:0] ACT_FLOOD   = 3'd0;
    localparam logic [2:0] ACT_REPLY   = 3'd1;
    localparam logic [2:0] ACT_FWD_REP = 3'd2;
    localparam logic [2:0] ACT_FWD_DAT = 3'd3;
    localparam logic [2:0] ACT_DELIVER = 3'd4;
    localparam logic [2:0] ACT_HOLD    = 3'd5;
    localparam logic [2:0] ACT_FOUND   = 3'd6;

    // Configuration register indexes
    localparam logic CFG_STALE = 1'b0;
    localparam logic CFG_SELF  = 1'b1;

    typedef struct packed {
        logic [2:0]       action;
        logic [MAC_W-1:0] peer_mac;
        logic [3:0]       out_port;
        logic [3:0]       from_node;
        logic [3:0]       to_node;
        logic [7:0]       hops_out;
        logic [15:0]      bcast_out;
        logic             reply_flag_out;
        logic             forced_out;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_s;
        logic upd_s;
        logic rd_d;
        logic dec;
        logic sel;
        logic clr;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       skip;
        logic [1:0] nres;
        logic       clr_done;
    } status_t;

endpackage

[sv/on_demand_route_table.sv]
// Items are taken only in idle; each accepted item passes the ST_RDS, ST_UPDS, ST_RDD and
// ST_DEC steps, the read-modify-write steps on the route table RAM, before its first result
// beat, of none, one or two, is presented in ST_OUT0. An item that is dropped (absent node or
// own request returning) goes back to idle from ST_RDS; output stalls hold the result beats.
// Reset: synchronous, active low; a clearing pass over all 2^(2*ceil(log2(NODE_COUNT))) entries
// (256 at default) zeroes the tables with s_tready low; config is taken throughout.
module on_demand_route_table import odrt_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_node, target_node, hops_in, bcast_id, reply_sent, forced, sender_mac,
    // arrival_port, now_seconds, zero fill
    input  logic [119:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // peer_mac, out_port, from_node, to_node, hops_out, bcast_out, reply_flag_out,
    // forced_out, zero fill
    output logic [87:0]  m_tdata,
    // action
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    cmd_t    cmd;
    status_t status;

    odrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    odrt_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[sv/odrt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module odrt_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/odrt_ctrl.sv]
// Sequencer of the route table engine: clear pass, table access steps, result beats.
`include "on_demand_route_table_macros.svh"
module odrt_ctrl import odrt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output logic    m_tlast,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_RDS   = 8'b0000_0100,
        ST_UPDS  = 8'b0000_1000,
        ST_RDD   = 8'b0001_0000,
        ST_DEC   = 8'b0010_0000,
        ST_OUT0  = 8'b0100_0000,
        ST_OUT1  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Handshake outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ((state_reg == ST_OUT0) && (status.nres != 2'd0))
                      || (state_reg == ST_OUT1);
    assign m_tlast  = ((state_reg == ST_OUT0) && (status.nres == 2'd1))
                      || (state_reg == ST_OUT1);

    // Datapath commands
    always_comb begin
        cmd       = '0;
        cmd.clr   = (state_reg == ST_CLEAR);
        cmd.load  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.rd_s  = (state_reg == ST_RDS);
        cmd.upd_s = (state_reg == ST_UPDS);
        cmd.rd_d  = (state_reg == ST_RDD);
        cmd.dec   = (state_reg == ST_DEC);
        cmd.sel   = (state_reg == ST_OUT1);
    end

    // Advance through the access steps
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (status.clr_done) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_RDS;
            ST_RDS:   state_next = status.skip ? ST_IDLE : ST_UPDS;
            ST_UPDS:  state_next = ST_RDD;
            ST_RDD:   state_next = ST_DEC;
            ST_DEC:   state_next = ST_OUT0;
            ST_OUT0: begin
                if (status.nres == 2'd0) begin
                    state_next = ST_IDLE;
                end else if (m_tready) begin
                    state_next = (status.nres == 2'd1) ? ST_IDLE : ST_OUT1;
                end
            end
            ST_OUT1:  if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `ODRT_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "input taken while a result beat is out")
    `ODRT_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready, state_reg == ST_RDS, "accept did not start a lookup")
    `ODRT_ASSERT_NEXT(a_last_ends, m_tvalid && m_tready && m_tlast, s_tready, "final beat did not return to idle")
    `ODRT_ASSERT_NOW(a_last_valid, m_tlast, m_tvalid, "tlast without a result beat")

endmodule

[sv/odrt_dp.sv]
// Datapath of the route table engine: item register, tables, staleness checks, results.
module odrt_dp import odrt_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic [119:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  cmd_t         cmd,
    output status_t      status,
    output logic [87:0]  m_tdata,
    output logic [2:0]   m_tuser
);

    localparam int IW         = $clog2(NODE_COUNT);
    localparam int RT_DEPTH   = 1 << IW;
    localparam int SEEN_AW    = 2 * IW;
    localparam int SEEN_DEPTH = 1 << SEEN_AW;

    // Configuration
    logic [15:0] stale_reg;
    logic [3:0]  self_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_reg <= 16'd5;
            self_reg  <= 4'd1;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_STALE) stale_reg <= cfg_wdata;
            if (cfg_addr == CFG_SELF)  self_reg  <= cfg_wdata[3:0];
        end
    end

    // Item register
    logic [1:0]       kind_reg;
    logic [3:0]       src_reg, dst_reg, aport_reg;
    logic [7:0]       hin_reg;
    logic [15:0]      id_reg;
    logic             rsent_reg, frc_reg;
    logic [MAC_W-1:0] mac_reg;
    logic [31:0]      now_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_tuser;
            src_reg   <= s_tdata[3:0];
            dst_reg   <= s_tdata[7:4];
            hin_reg   <= s_tdata[15:8];
            id_reg    <= s_tdata[31:16];
            rsent_reg <= s_tdata[32];
            frc_reg   <= s_tdata[33];
            mac_reg   <= s_tdata[81:34];
            aport_reg <= s_tdata[85:82];
            now_reg   <= s_tdata[117:86];
        end
    end

    logic [7:0]    hop;
    logic [IW-1:0] src_idx, dst_idx;

    assign hop     = (hin_reg == 8'hFF) ? 8'hFF : hin_reg + 8'd1;
    assign src_idx = IW'(src_reg);
    assign dst_idx = IW'(dst_reg);

    // Drop items naming absent nodes and requests we sent ourselves
    assign status.skip = (32'(dst_reg) >= NODE_COUNT)
                         || ((kind_reg != KIND_LOCAL) && (32'(src_reg) >= NODE_COUNT))
                         || ((kind_reg == KIND_RREQ) && (src_reg == self_reg));

    // Clearing pass after reset
    logic [SEEN_AW:0] clr_cnt_reg;
    logic             clr_act;

    assign status.clr_done = (clr_cnt_reg == (SEEN_AW+1)'(SEEN_DEPTH));
    assign clr_act         = cmd.clr && !status.clr_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clr_act) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Tables
    logic                 rt_we, seen_we;
    logic [IW-1:0]        rt_waddr, rt_raddr;
    logic [RT_WORD_W-1:0] rt_wdata, rt_q;
    logic [SEEN_AW-1:0]   seen_waddr, seen_raddr;
    logic [15:0]          seen_wdata, seen_q;

    odrt_ram #(.W(RT_WORD_W), .DEPTH(RT_DEPTH)) u_rt (
        .aclk  (aclk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (rt_raddr),
        .rdata (rt_q)
    );

    odrt_ram #(.W(16), .DEPTH(SEEN_DEPTH)) u_seen (
        .aclk  (aclk),
        .we    (seen_we),
        .waddr (seen_waddr),
        .wdata (seen_wdata),
        .raddr (seen_raddr),
        .rdata (seen_q)
    );

    // Route entry just read
    logic [MAC_W-1:0] q_nh;
    logic [3:0]       q_port;
    logic [7:0]       q_hops;
    logic [31:0]      q_stamp;
    logic [32:0]      limit;
    logic             nh_zero, time_fresh, time_stale;

    assign {q_stamp, q_hops, q_port, q_nh} = rt_q;
    assign limit      = {1'b0, q_stamp} + 33'(stale_reg);
    assign time_fresh = limit > {1'b0, now_reg};
    assign time_stale = limit < {1'b0, now_reg};
    assign nh_zero    = (q_nh == '0);

    assign rt_raddr   = cmd.rd_s ? src_idx : dst_idx;
    assign seen_raddr = cmd.rd_s ? {src_idx, src_idx} : {dst_idx, src_idx};

    // Source route update
    logic upd_s;
    logic newer;

    assign newer = id_reg > seen_q;

    always_comb begin
        upd_s = 1'b0;
        case (kind_reg)
            KIND_RREQ: begin
                upd_s = !((hop > q_hops) || time_fresh);
                if (newer && frc_reg) upd_s = 1'b1;
                if (nh_zero) upd_s = 1'b1;
            end
            KIND_RREP: upd_s = frc_reg || (hop < q_hops) || nh_zero || time_stale;
            KIND_DATA: upd_s = 1'b1;
            default:   upd_s = 1'b0;
        endcase
    end

    logic [MAC_W-1:0] rs_nh_reg;
    logic [3:0]       rs_port_reg;
    logic [7:0]       rs_hops_reg, orig_hops_reg;
    logic             seen_src_reg;

    always_ff @(posedge aclk) begin
        if (cmd.upd_s) begin
            rs_nh_reg     <= upd_s ? mac_reg : q_nh;
            rs_port_reg   <= upd_s ? aport_reg : q_port;
            rs_hops_reg   <= upd_s ? hop : q_hops;
            orig_hops_reg <= q_hops;
            seen_src_reg  <= !nh_zero;
        end
    end

    // Destination decision
    function automatic result_t mk(input logic [2:0] act, input logic [MAC_W-1:0] mac,
                                   input logic [3:0] port, input logic [3:0] from,
                                   input logic [3:0] to, input logic [7:0] hops,
                                   input logic [15:0] bc, input logic rf, input logic fo);
        result_t r;
        r.action         = act;
        r.peer_mac       = mac;
        r.out_port       = port;
        r.from_node      = from;
        r.to_node        = to;
        r.hops_out       = hops;
        r.bcast_out      = bc;
        r.reply_flag_out = rf;
        r.forced_out     = fo;
        return r;
    endfunction

    logic [15:0] own_bcast_reg, own_inc;
    result_t     r0, r1, res0_reg, res1_reg;
    logic [1:0]  n;
    logic        d_rt_we, d_seen_we, own_bump;
    logic [RT_WORD_W-1:0] d_rt_wdata;
    logic        d_fresh, d_missing;
    logic [MAC_W-1:0] eff_nh;

    assign own_inc   = (own_bcast_reg == 16'hFFFF) ? own_bcast_reg : own_bcast_reg + 16'd1;
    assign eff_nh    = ((kind_reg == KIND_LOCAL) && frc_reg) ? '0 : q_nh;
    assign d_fresh   = (eff_nh != '0) && time_fresh;
    assign d_missing = (eff_nh == '0) || time_stale;

    always_comb begin
        r0         = '0;
        r1         = '0;
        n          = 2'd0;
        d_rt_we    = 1'b0;
        d_seen_we  = 1'b0;
        own_bump   = 1'b0;
        d_rt_wdata = rt_q;
        case (kind_reg)
            KIND_RREQ: begin
                if (newer) begin
                    d_seen_we = 1'b1;
                    if (dst_reg != self_reg) begin
                        if (d_missing) begin
                            r0 = mk(ACT_FLOOD, MAC_BCAST, 4'd0, src_reg, dst_reg, hop,
                                    id_reg, rsent_reg, frc_reg);
                            n  = 2'd1;
                        end else if (d_fresh) begin
                            if (!frc_reg) begin
                                d_rt_we    = 1'b1;
                                d_rt_wdata = {now_reg, q_hops, q_port, q_nh};
                                if (!rsent_reg) begin
                                    r0 = mk(ACT_REPLY, rs_nh_reg, rs_port_reg, dst_reg,
                                            src_reg, 8'd0, id_reg, 1'b0, 1'b0);
                                    r1 = mk(ACT_FLOOD, MAC_BCAST, 4'd0, src_reg, dst_reg,
                                            hop, id_reg, 1'b1, 1'b0);
                                    n  = (!seen_src_reg || (orig_hops_reg > hop))
                                         ? 2'd2 : 2'd1;
                                end
                            end else begin
                                r0 = mk(ACT_FLOOD, MAC_BCAST, 4'd0, src_reg, dst_reg, hop,
                                        id_reg, rsent_reg, frc_reg);
                                n  = 2'd1;
                            end
                        end
                    end else if (!rsent_reg) begin
                        r0 = mk(ACT_REPLY, rs_nh_reg, rs_port_reg, dst_reg, src_reg, 8'd0,
                                id_reg, 1'b0, frc_reg);
                        r1 = mk(ACT_FLOOD, MAC_BCAST, 4'd0, src_reg, dst_reg, hop, id_reg,
                                1'b1, frc_reg);
                        n  = (!seen_src_reg || (orig_hops_reg > hop)) ? 2'd2 : 2'd1;
                    end
                end
            end
            KIND_RREP: begin
                n = 2'd1;
                if (dst_reg == self_reg) begin
                    r0 = mk(ACT_FOUND, rs_nh_reg, rs_port_reg, src_reg, dst_reg,
                            rs_hops_reg, id_reg, 1'b0, frc_reg);
                end else begin
                    r0 = mk(ACT_FWD_REP, q_nh, q_port, src_reg, dst_reg, hop, id_reg,
                            rsent_reg, frc_reg);
                end
            end
            KIND_DATA: begin
                if (dst_reg == self_reg) begin
                    r0 = mk(ACT_DELIVER, mac_reg, aport_reg, src_reg, dst_reg, hop, 16'd0,
                            1'b0, frc_reg);
                    n  = 2'd1;
                end else if (d_fresh) begin
                    r0 = mk(ACT_FWD_DAT, q_nh, q_port, src_reg, dst_reg, hop, 16'd0,
                            1'b0, frc_reg);
                    n  = 2'd1;
                end else begin
                    own_bump = 1'b1;
                    r0 = mk(ACT_HOLD, '0, 4'd0, src_reg, dst_reg, hop, 16'd0, 1'b0, frc_reg);
                    r1 = mk(ACT_FLOOD, MAC_BCAST, 4'd0, self_reg, dst_reg, 8'd0, own_inc,
                            1'b0, 1'b1);
                    n  = 2'd2;
                end
            end
            default: begin
                own_bump = 1'b1;
                if (frc_reg) begin
                    d_rt_we    = 1'b1;
                    d_rt_wdata = {q_stamp, q_hops, q_port, {MAC_W{1'b0}}};
                end
                if (d_fresh) begin
                    r1 = mk(ACT_FWD_DAT, q_nh, q_port, self_reg, dst_reg, 8'd0, 16'd0,
                            1'b0, frc_reg);
                end else begin
                    r1 = mk(ACT_HOLD, '0, 4'd0, self_reg, dst_reg, 8'd0, 16'd0, 1'b0,
                            frc_reg);
                end
                if (d_missing) begin
                    r0 = mk(ACT_FLOOD, MAC_BCAST, 4'd0, self_reg, dst_reg, 8'd0, own_inc,
                            1'b0, frc_reg);
                    n  = 2'd2;
                end else begin
                    r0 = r1;
                    n  = 2'd1;
                end
            end
        endcase
    end

    // Table write port selection
    always_comb begin
        if (clr_act) begin
            rt_we      = (clr_cnt_reg < (SEEN_AW+1)'(RT_DEPTH));
            rt_waddr   = clr_cnt_reg[IW-1:0];
            rt_wdata   = '0;
            seen_we    = 1'b1;
            seen_waddr = clr_cnt_reg[SEEN_AW-1:0];
            seen_wdata = '0;
        end else if (cmd.upd_s) begin
            rt_we      = upd_s;
            rt_waddr   = src_idx;
            rt_wdata   = {now_reg, hop, aport_reg, mac_reg};
            seen_we    = ((kind_reg == KIND_RREQ) && newer)
                         || ((kind_reg == KIND_RREP) && upd_s);
            seen_waddr = {src_idx, src_idx};
            seen_wdata = id_reg;
        end else begin
            rt_we      = cmd.dec && d_rt_we;
            rt_waddr   = dst_idx;
            rt_wdata   = d_rt_wdata;
            seen_we    = cmd.dec && d_seen_we;
            seen_waddr = {dst_idx, src_idx};
            seen_wdata = id_reg;
        end
    end

    // Hold results and own broadcast id
    logic [1:0] nres_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_bcast_reg <= '0;
            nres_reg      <= '0;
        end else if (cmd.dec) begin
            nres_reg <= n;
            if (own_bump) own_bcast_reg <= own_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dec) begin
            res0_reg <= r0;
            res1_reg <= r1;
        end
    end

    assign status.nres = nres_reg;

    // Result beat
    result_t rsel;

    assign rsel    = cmd.sel ? res1_reg : res0_reg;
    assign m_tuser = rsel.action;
    assign m_tdata = {2'b00, rsel.forced_out, rsel.reply_flag_out, rsel.bcast_out,
                      rsel.hops_out, rsel.to_node, rsel.from_node, rsel.out_port,
                      rsel.peer_mac};

endmodule

[sim/on_demand_route_table_tb.sv]
// Self-checking testbench for the on-demand route table engine.
module on_demand_route_table_tb;
    import odrt_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  origin;
        logic [3:0]  target;
        logic [7:0]  hops;
        logic [15:0] bid;
        logic        rsent;
        logic        forced;
        logic [47:0] mac;
        logic [3:0]  port;
        logic [31:0] now;
    } packet_t;

    typedef struct {
        result_t r;
        logic    last;
    } action_beat_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic         cfg_addr;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    on_demand_route_table i_dut (.*);

    // Shadow route table
    logic [47:0] nh_tab[16];
    logic [3:0]  port_tab[16];
    logic [7:0]  hops_tab[16];
    logic [31:0] stamp_tab[16];
    logic [15:0] seen_tab[256];
    logic [15:0] own_id;
    logic [15:0] stale_cfg;
    logic [3:0]  self_cfg;

    packet_t      pkt_pending[$];
    action_beat_t action_expected[$];
    packet_t      cur_pkt;
    int           s_idle_pct;
    int           m_idle_pct;
    int           errors;
    int           pkts_sent;
    int           beats_checked;
    int           cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic stamp_fresh(logic [3:0] n, logic [31:0] now);
        return ({1'b0, stamp_tab[n]} + {17'd0, stale_cfg}) > {1'b0, now};
    endfunction

    function automatic logic route_fresh(logic [3:0] n, logic [31:0] now);
        return nh_tab[n] != '0 && stamp_fresh(n, now);
    endfunction

    function automatic logic route_missing_or_stale(logic [3:0] n, logic [31:0] now);
        return nh_tab[n] == '0 || ({1'b0, stamp_tab[n]} + {17'd0, stale_cfg}) < {1'b0, now};
    endfunction

    function automatic result_t mk_act(logic [2:0] a, logic [47:0] mac, logic [3:0] port,
                                       logic [3:0] from, logic [3:0] to, logic [7:0] hops,
                                       logic [15:0] bc, logic rf, logic fo);
        result_t r;
        r.action = a; r.peer_mac = mac; r.out_port = port; r.from_node = from;
        r.to_node = to; r.hops_out = hops; r.bcast_out = bc;
        r.reply_flag_out = rf; r.forced_out = fo;
        return r;
    endfunction

    // Update the shadow table for one packet and queue the actions it causes
    task automatic route_packet(packet_t p);
        result_t     acts[2];
        int          n;
        logic [7:0]  hop;
        logic [3:0]  s;
        logic [3:0]  d;
        logic        seen_src;
        logic        upd;
        logic [7:0]  orig_hops;
        action_beat_t b;
        n = 0;
        s = p.origin;
        d = p.target;
        hop = (p.hops == 8'hFF) ? 8'hFF : p.hops + 8'd1;
        case (p.kind)
            KIND_RREQ: begin
                if (s == self_cfg) return;
                seen_src = nh_tab[s] != '0;
                orig_hops = hops_tab[s];
                upd = 1'b1;
                if (hop > hops_tab[s] || stamp_fresh(s, p.now)) upd = 1'b0;
                if (p.bid > seen_tab[{s, s}]) begin
                    if (p.forced) upd = 1'b1;
                    seen_tab[{s, s}] = p.bid;
                end
                if (nh_tab[s] == '0) upd = 1'b1;
                if (upd) begin
                    nh_tab[s] = p.mac; port_tab[s] = p.port;
                    hops_tab[s] = hop; stamp_tab[s] = p.now;
                end
                if (p.bid > seen_tab[{d, s}]) seen_tab[{d, s}] = p.bid;
                else return;
                if (d != self_cfg) begin
                    if (route_missing_or_stale(d, p.now)) begin
                        acts[n++] = mk_act(ACT_FLOOD, MAC_BCAST, 0, s, d, hop, p.bid,
                                           p.rsent, p.forced);
                    end else if (route_fresh(d, p.now)) begin
                        if (!p.forced) begin
                            stamp_tab[d] = p.now;
                            if (!p.rsent) begin
                                acts[n++] = mk_act(ACT_REPLY, nh_tab[s], port_tab[s], d, s,
                                                   0, p.bid, 0, 0);
                                if (!seen_src || orig_hops > hop)
                                    acts[n++] = mk_act(ACT_FLOOD, MAC_BCAST, 0, s, d, hop,
                                                       p.bid, 1, 0);
                            end
                        end else begin
                            acts[n++] = mk_act(ACT_FLOOD, MAC_BCAST, 0, s, d, hop, p.bid,
                                               p.rsent, p.forced);
                        end
                    end
                end else if (!p.rsent) begin
                    acts[n++] = mk_act(ACT_REPLY, nh_tab[s], port_tab[s], d, s, 0, p.bid,
                                       0, p.forced);
                    if (!seen_src || orig_hops > hop)
                        acts[n++] = mk_act(ACT_FLOOD, MAC_BCAST, 0, s, d, hop, p.bid, 1,
                                           p.forced);
                end
            end
            KIND_RREP: begin
                if (p.forced || hop < hops_tab[s] || route_missing_or_stale(s, p.now)) begin
                    nh_tab[s] = p.mac; port_tab[s] = p.port;
                    hops_tab[s] = hop; stamp_tab[s] = p.now;
                    seen_tab[{s, s}] = p.bid;
                end
                if (d == self_cfg)
                    acts[n++] = mk_act(ACT_FOUND, nh_tab[s], port_tab[s], s, d, hops_tab[s],
                                       p.bid, 0, p.forced);
                else
                    acts[n++] = mk_act(ACT_FWD_REP, nh_tab[d], port_tab[d], s, d, hop, p.bid,
                                       p.rsent, p.forced);
            end
            KIND_DATA: begin
                nh_tab[s] = p.mac; port_tab[s] = p.port;
                hops_tab[s] = hop; stamp_tab[s] = p.now;
                if (d == self_cfg) begin
                    acts[n++] = mk_act(ACT_DELIVER, p.mac, p.port, s, d, hop, 0, 0, p.forced);
                end else if (route_fresh(d, p.now)) begin
                    acts[n++] = mk_act(ACT_FWD_DAT, nh_tab[d], port_tab[d], s, d, hop, 0, 0,
                                       p.forced);
                end else begin
                    acts[n++] = mk_act(ACT_HOLD, 0, 0, s, d, hop, 0, 0, p.forced);
                    if (own_id != 16'hFFFF) own_id++;
                    acts[n++] = mk_act(ACT_FLOOD, MAC_BCAST, 0, self_cfg, d, 0, own_id, 0, 1);
                end
            end
            default: begin
                if (own_id != 16'hFFFF) own_id++;
                if (p.forced) nh_tab[d] = '0;
                if (route_missing_or_stale(d, p.now))
                    acts[n++] = mk_act(ACT_FLOOD, MAC_BCAST, 0, self_cfg, d, 0, own_id, 0,
                                       p.forced);
                if (route_fresh(d, p.now))
                    acts[n++] = mk_act(ACT_FWD_DAT, nh_tab[d], port_tab[d], self_cfg, d, 0,
                                       0, 0, p.forced);
                else
                    acts[n++] = mk_act(ACT_HOLD, 0, 0, self_cfg, d, 0, 0, 0, p.forced);
            end
        endcase
        for (int i = 0; i < n; i++) begin
            b.r = acts[i];
            b.last = (i == n - 1);
            action_expected.push_back(b);
        end
    endtask

    // Driver: account for the accepted beat, then present the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                route_packet(cur_pkt);
                pkts_sent++;
            end
            if (pkt_pending.size() > 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                cur_pkt = pkt_pending.pop_front();
                s_tdata <= {2'b00, cur_pkt.now, cur_pkt.port, cur_pkt.mac, cur_pkt.forced,
                            cur_pkt.rsent, cur_pkt.bid, cur_pkt.hops, cur_pkt.target,
                            cur_pkt.origin};
                s_tuser <= cur_pkt.kind;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge aclk) begin
        action_beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beats_checked++;
            if (action_expected.size() == 0) begin
                $error("unexpected result beat, action %0d", m_tuser);
                errors++;
            end else begin
                e = action_expected.pop_front();
                if (m_tuser !== e.r.action) begin
                    $error("action: expected %0d, got %0d", e.r.action, m_tuser);
                    errors++;
                end
                if (m_tdata[47:0] !== e.r.peer_mac) begin
                    $error("peer_mac: expected %h, got %h", e.r.peer_mac, m_tdata[47:0]);
                    errors++;
                end
                if (m_tdata[51:48] !== e.r.out_port) begin
                    $error("out_port: expected %0d, got %0d", e.r.out_port, m_tdata[51:48]);
                    errors++;
                end
                if (m_tdata[55:52] !== e.r.from_node) begin
                    $error("from_node: expected %0d, got %0d", e.r.from_node, m_tdata[55:52]);
                    errors++;
                end
                if (m_tdata[59:56] !== e.r.to_node) begin
                    $error("to_node: expected %0d, got %0d", e.r.to_node, m_tdata[59:56]);
                    errors++;
                end
                if (m_tdata[67:60] !== e.r.hops_out) begin
                    $error("hops_out: expected %0d, got %0d", e.r.hops_out, m_tdata[67:60]);
                    errors++;
                end
                if (m_tdata[83:68] !== e.r.bcast_out) begin
                    $error("bcast_out: expected %0d, got %0d", e.r.bcast_out, m_tdata[83:68]);
                    errors++;
                end
                if (m_tdata[84] !== e.r.reply_flag_out) begin
                    $error("reply_flag_out: expected %0d, got %0d", e.r.reply_flag_out,
                           m_tdata[84]);
                    errors++;
                end
                if (m_tdata[85] !== e.r.forced_out) begin
                    $error("forced_out: expected %0d, got %0d", e.r.forced_out, m_tdata[85]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic packet_t mk_pkt(logic [1:0] kind, logic [3:0] o, logic [3:0] t,
                                       logic [7:0] h, logic [15:0] id, logic rs, logic fo,
                                       logic [47:0] mac, logic [3:0] port, logic [31:0] now);
        packet_t p;
        p.kind = kind; p.origin = o; p.target = t; p.hops = h; p.bid = id;
        p.rsent = rs; p.forced = fo; p.mac = mac; p.port = port; p.now = now;
        return p;
    endfunction

    // Drive one register write; the caller drops cfg_we after its last write
    task automatic write_reg(logic addr, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        if (addr == CFG_STALE) stale_cfg = val;
        else self_cfg = val[3:0];
    endtask

    // Wait for all traffic to drain, then let in-flight no-result items finish
    task automatic drain();
        do @(posedge aclk);
        while (pkt_pending.size() > 0 || s_tvalid || action_expected.size() > 0);
        repeat (20) @(posedge aclk);
    endtask

    // Mostly plausible protocol traffic on a slowly moving clock, with some noise
    task automatic queue_random(int count);
        logic [47:0] mac_pool[8];
        logic [31:0] clk_s;
        logic [15:0] id_seq;
        packet_t     p;
        int          k;
        clk_s = $urandom_range(0, 1000);
        id_seq = $urandom_range(0, 50);
        foreach (mac_pool[i]) mac_pool[i] = {$urandom, $urandom} | 48'd1;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            p.kind = (k < 35) ? KIND_RREQ : (k < 55) ? KIND_RREP : (k < 80) ? KIND_DATA
                   : KIND_LOCAL;
            p.origin = ($urandom_range(0, 5) == 0) ? self_cfg : 4'($urandom_range(0, 15));
            p.target = ($urandom_range(0, 4) == 0) ? self_cfg : 4'($urandom_range(0, 15));
            p.hops = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
            if ($urandom_range(0, 19) == 0) id_seq = $urandom;
            else if (id_seq < 16'hFFF0) id_seq += $urandom_range(0, 2);
            p.bid = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) : id_seq;
            p.rsent = ($urandom_range(0, 3) == 0);
            p.forced = ($urandom_range(0, 4) == 0);
            k = $urandom_range(0, 19);
            p.mac = (k == 0) ? 48'd0 : (k == 1) ? {$urandom, $urandom}
                  : mac_pool[$urandom_range(0, 7)];
            p.port = $urandom_range(0, 15);
            k = $urandom_range(0, 99);
            if (k == 0) clk_s = $urandom;
            else if (k < 4) clk_s += $urandom_range(0, 20);
            else clk_s += $urandom_range(0, 2);
            p.now = clk_s;
            pkt_pending.push_back(p);
        end
    endtask

    initial begin
        logic [47:0] ma;
        logic [47:0] mb;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_STALE;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_RREQ;
        m_tready = 1'b0;
        s_idle_pct = 0;
        m_idle_pct = 0;
        errors = 0;
        pkts_sent = 0;
        beats_checked = 0;
        cycles = 0;
        own_id = '0;
        stale_cfg = 16'd5;
        self_cfg = 4'd1;
        foreach (nh_tab[i]) begin
            nh_tab[i] = '0; port_tab[i] = '0; hops_tab[i] = '0; stamp_tab[i] = '0;
        end
        foreach (seen_tab[i]) seen_tab[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every kind and action, duplicates, own request, boundary stamp
        ma = 48'h0A0B0C0D0E0F;
        mb = 48'h112233445566;
        pkt_pending.push_back(mk_pkt(KIND_DATA, 2, 1, 0, 0, 0, 0, ma, 3, 10));
        pkt_pending.push_back(mk_pkt(KIND_RREQ, 3, 1, 1, 1, 0, 0, mb, 5, 10));
        pkt_pending.push_back(mk_pkt(KIND_RREQ, 3, 1, 1, 1, 0, 0, mb, 5, 10));
        pkt_pending.push_back(mk_pkt(KIND_RREQ, 1, 6, 0, 9, 0, 0, mb, 5, 10));
        pkt_pending.push_back(mk_pkt(KIND_LOCAL, 0, 3, 0, 0, 0, 0, 0, 0, 11));
        pkt_pending.push_back(mk_pkt(KIND_LOCAL, 0, 9, 0, 0, 0, 0, 0, 0, 11));
        pkt_pending.push_back(mk_pkt(KIND_LOCAL, 0, 3, 0, 0, 0, 1, 0, 0, 11));
        pkt_pending.push_back(mk_pkt(KIND_RREP, 4, 1, 2, 7, 0, 0, ma, 2, 11));
        pkt_pending.push_back(mk_pkt(KIND_RREP, 4, 5, 2, 8, 1, 1, mb, 6, 11));
        pkt_pending.push_back(mk_pkt(KIND_DATA, 4, 6, 3, 0, 0, 0, ma, 2, 12));
        pkt_pending.push_back(mk_pkt(KIND_DATA, 5, 4, 0, 0, 0, 0, mb, 7, 12));
        pkt_pending.push_back(mk_pkt(KIND_RREQ, 5, 4, 0, 20, 0, 0, mb, 7, 12));
        pkt_pending.push_back(mk_pkt(KIND_RREQ, 6, 4, 0, 21, 0, 1, ma, 1, 12));
        pkt_pending.push_back(mk_pkt(KIND_RREQ, 7, 4, 0, 22, 1, 0, ma, 1, 12));
        pkt_pending.push_back(mk_pkt(KIND_LOCAL, 0, 2, 0, 0, 0, 0, 0, 0, 15));
        pkt_pending.push_back(mk_pkt(KIND_RREQ, 8, 1, 8'hFF, 16'hFFFF, 0, 1, MAC_BCAST, 15,
                                     32'hFFFFFFFF));
        pkt_pending.push_back(mk_pkt(KIND_RREP, 9, 1, 8'hFE, 16'hFFFF, 1, 1, MAC_BCAST, 15,
                                     32'hFFFFFFFF));
        pkt_pending.push_back(mk_pkt(KIND_DATA, 15, 15, 8'hFF, 0, 1, 1, MAC_BCAST, 15,
                                     32'hFFFFFFFF));
        pkt_pending.push_back(mk_pkt(KIND_LOCAL, 15, 8, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
        pkt_pending.push_back(mk_pkt(KIND_RREQ, 0, 0, 0, 5, 0, 0, 48'd0, 0, 0));
        drain();

        // Random phases over several settings and idling mixes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(CFG_STALE, 5);      write_reg(CFG_SELF, 1);  end
                1: begin write_reg(CFG_STALE, 1);      write_reg(CFG_SELF, 0);  end
                2: begin write_reg(CFG_STALE, 16'hFFFF); write_reg(CFG_SELF, 15); end
                3: begin write_reg(CFG_STALE, 3);      write_reg(CFG_SELF, 7);  end
                default: begin
                    write_reg(CFG_STALE, $urandom_range(1, 12));
                    write_reg(CFG_SELF, $urandom_range(0, 15));
                end
            endcase
            cfg_we <= 1'b0;
            s_idle_pct = (ph == 1 || ph == 4) ? 53 : (ph == 3) ? 11 : 0;
            m_idle_pct = (ph == 2 || ph == 4) ? 53 : (ph == 3) ? 11 : 0;
            queue_random(266);
            drain();
        end

        $display("Sent %0d route packets over five table settings; %0d action beats checked",
                 pkts_sent, beats_checked);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
